>>> hdl/bae_pkg.sv
package bae_pkg;

  localparam logic [1:0] MODE_INTERVAL = 2'd0;
  localparam logic [1:0] MODE_SYMBOL   = 2'd1;
  localparam logic [1:0] MODE_CONCLUDE = 2'd2;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_BAD = 2'd1;
  localparam logic [1:0] STATUS_SAT = 2'd2;

  localparam logic [24:0] PROB_ONE   = 25'h1000000;
  localparam logic [31:0] SPACE_MASK = 32'hffffff00;
  localparam int          MAX_RESULTS = 32;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] prob_low;
    logic [24:0] prob_high;
    logic [23:0] num_symbols;
    logic [23:0] symbol_index;
  } in_word_t;

  typedef struct packed {
    logic        bit_valid;
    logic        lead_bit;
    logic [15:0] run_count;
    logic [1:0]  status;
    logic        last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_CHECK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADJ,
    ST_EMIT,
    ST_E3,
    ST_FIN,
    ST_CONC,
    ST_CEMIT,
    ST_OUT
  } state_t;

endpackage

>>> hdl/binary_arithmetic_encoder_unit.sv
// Sequence: mode 0 runs check, two 25-step shift-add multiplies, adjust and emit after
//   accept; mode 1 first adds two 49-step restoring divides. Conclude searches, then emits.
// One item at a time: a new item is accepted only in idle, after the previous one closed.
//   Each item emits its bit words, takes its E3 rescale steps and closes; every output
//   word is held until taken, so output stalls hold the unit.
// Reset (rst, synchronous): low = 0, high = all ones, underflow count = 0, idle.
module binary_arithmetic_encoder_unit
  import bae_pkg::*;
#(
  parameter int UF_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam logic [UF_WIDTH-1:0] UF_MAX = '1;

  state_t state, state_next, ret;
  in_word_t item;
  logic [31:0] range_low, range_high;
  logic [UF_WIDTH-1:0] pending;
  logic [31:0] lo, hi;
  logic [24:0] pl, ph;
  logic [31:0] space;
  logic [49:0] rem;
  logic [48:0] quo;
  logic [56:0] acc;
  logic [24:0] mplier;
  logic [5:0]  cnt;
  logic [5:0]  nres;
  logic [1:0]  status;
  logic [31:0] mean, cv, cmask;
  out_word_t   obuf;

  logic [49:0] rem_shift;
  logic [24:0] div_res;
  logic [31:0] emit_run;
  logic [31:0] dv;
  logic        emit_now;
  logic        emit_more;

  assign rem_shift = {rem[48:0], quo[48]};
  assign div_res = quo[24:0];
  assign emit_run = 32'(pending);
  assign dv = range_high - range_low;
  assign emit_now = !(lo[31] ^ hi[31]) && nres < 6'(MAX_RESULTS);
  assign emit_more = (lo[30] == hi[30]) && nres < 6'(MAX_RESULTS - 1);

  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign out_data = obuf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      range_low <= '0;
      range_high <= '1;
      pending <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (in_valid) begin
          item <= in_data;
          status <= STATUS_OK;
          nres <= '0;
          cnt <= '0;
          pl <= {1'b0, in_data.prob_low};
          ph <= in_data.prob_high;
          rem <= '0;
          quo <= {1'b0, in_data.symbol_index, 24'd0};
        end
        ST_DIV_LO, ST_DIV_HI: begin
          if (rem_shift >= 50'(item.num_symbols)) begin
            rem <= rem_shift - 50'(item.num_symbols);
            quo <= {quo[47:0], 1'b1};
          end else begin
            rem <= rem_shift;
            quo <= {quo[47:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd48) begin
            cnt <= '0;
            rem <= '0;
            if (state == ST_DIV_LO) begin
              pl <= (rem_shift >= 50'(item.num_symbols)) ? {div_res[23:0], 1'b1}
                                                           : {div_res[23:0], 1'b0};
              quo <= {1'b0, item.symbol_index + 24'd1, 24'd0};
            end else begin
              ph <= (rem_shift >= 50'(item.num_symbols)) ? {div_res[23:0], 1'b1}
                                                         : {div_res[23:0], 1'b0};
              if (item.symbol_index == item.num_symbols - 24'd1) ph <= PROB_ONE;
            end
          end
        end
        ST_CHECK: begin
          space <= (range_high - range_low) & SPACE_MASK;
          acc <= '0;
          mplier <= pl;
          cnt <= '0;
        end
        ST_MUL_LO, ST_MUL_HI: begin
          acc <= (mplier[24] ? acc + 57'(space) : acc);
          if (cnt != 6'd24) begin
            acc <= {(mplier[24] ? acc + 57'(space) : acc)} << 1;
            mplier <= mplier << 1;
            cnt <= cnt + 6'd1;
          end else begin
            cnt <= '0;
            if (state == ST_MUL_LO) begin
              lo <= range_low + 32'(((mplier[24] ? acc + 57'(space) : acc)) >> 24);
              acc <= '0;
              mplier <= ph;
            end else begin
              hi <= range_low + 32'(((mplier[24] ? acc + 57'(space) : acc)) >> 24) - 32'd1;
            end
          end
        end
        ST_ADJ: if (ph >= PROB_ONE) hi <= range_high;
        ST_EMIT: if (emit_now) begin
          obuf <= '{bit_valid: 1'b1, lead_bit: lo[31], run_count: emit_run[15:0],
                    status: STATUS_OK, last: 1'b0};
          pending <= '0;
          lo <= lo << 1;
          hi <= {hi[30:0], 1'b1};
          nres <= nres + 6'd1;
          ret <= ST_EMIT;
        end
        ST_E3: begin
          if (pending < UF_MAX) pending <= pending + 1'b1;
          else status <= STATUS_SAT;
          lo <= {1'b0, lo[29:0], 1'b0};
          hi <= {1'b1, hi[29:0], 1'b1};
        end
        ST_FIN: begin
          if (item.mode == MODE_INTERVAL || item.mode == MODE_SYMBOL) begin
            if (status != STATUS_BAD) begin
              range_low <= lo;
              range_high <= hi;
            end
          end
          if (item.mode == MODE_CONCLUDE) begin
            range_low <= '0;
            range_high <= '1;
            pending <= '0;
          end
          if (nres == '0) obuf <= '{bit_valid: 1'b0, lead_bit: 1'b0, run_count: '0,
                                   status: status, last: 1'b1};
          else obuf <= '{bit_valid: obuf.bit_valid, lead_bit: obuf.lead_bit,
                         run_count: obuf.run_count, status: status, last: 1'b1};
          ret <= ST_IDLE;
        end
        ST_CONC: begin
          if (cnt == '0) begin
            mean <= (dv >> 1) + range_low;
            cv <= '0;
            cmask <= '1;
            cnt <= 6'd1;
          end else begin
            cv <= (mean >> (6'd32 - cnt)) << (6'd32 - cnt);
            cmask <= (cnt >= 6'd32) ? 32'd0 : (32'hffffffff >> cnt);
            cnt <= cnt + 6'd1;
          end
          lo <= '0;
        end
        ST_CEMIT: begin
          obuf <= '{bit_valid: 1'b1, lead_bit: cv[31],
                    run_count: (lo == '0) ? emit_run[15:0] : 16'd0,
                    status: STATUS_OK, last: 1'b0};
          cv <= cv << 1;
          lo <= lo + 32'd1;
          nres <= nres + 6'd1;
          ret <= ST_CEMIT;
        end
        default: ;
      endcase
      if (state == ST_CONC && state_next == ST_CEMIT) begin
        hi <= (cnt == '0) ? 32'd1 : 32'(cnt - 6'd1);
        if (cnt == '0) cv <= '1;
        else cv <= cv | cmask;
      end
      if (state == ST_CHECK && state_next == ST_FIN) status <= STATUS_BAD;
      if (state == ST_IDLE && in_valid && in_data.mode != MODE_INTERVAL &&
          in_data.mode != MODE_SYMBOL && in_data.mode != MODE_CONCLUDE)
        status <= STATUS_BAD;
      if (state == ST_IDLE && in_valid && in_data.mode == MODE_SYMBOL &&
          (in_data.num_symbols == '0 || in_data.symbol_index >= in_data.num_symbols))
        status <= STATUS_BAD;
    end
  end

  logic conc_done;
  logic [31:0] cspace;
  always_comb begin
    cspace = 32'hffffffff;
    conc_done = (cv >= range_low) && ({1'b0, cv} + {1'b0, cmask} <= {1'b0, range_high});
    if (cnt >= 6'd33) conc_done = 1'b1;
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) begin
        priority if (in_data.mode == MODE_INTERVAL) state_next = ST_CHECK;
        else if (in_data.mode == MODE_SYMBOL) begin
          if (in_data.num_symbols == '0 || in_data.symbol_index >= in_data.num_symbols)
            state_next = ST_FIN;
          else state_next = ST_DIV_LO;
        end
        else if (in_data.mode == MODE_CONCLUDE) state_next = ST_CONC;
        else state_next = ST_FIN;
      end
      ST_DIV_LO: if (cnt == 6'd48) state_next = ST_DIV_HI;
      ST_DIV_HI: if (cnt == 6'd48) state_next = ST_CHECK;
      ST_CHECK: begin
        if (pl > 25'hffffff || ph > PROB_ONE || pl >= ph ||
            ((range_high - range_low) & SPACE_MASK & cspace) < 32'(PROB_ONE))
          state_next = ST_FIN;
        else state_next = ST_MUL_LO;
      end
      ST_MUL_LO: if (cnt == 6'd24) state_next = ST_MUL_HI;
      ST_MUL_HI: if (cnt == 6'd24) state_next = ST_ADJ;
      ST_ADJ: state_next = ST_EMIT;
      ST_EMIT: begin
        // the final bit word is held until the status is known
        if (emit_now) state_next = emit_more ? ST_OUT : ST_EMIT;
        else if (lo[31:30] == 2'b01 && hi[31:30] == 2'b10) state_next = ST_E3;
        else state_next = ST_FIN;
      end
      ST_E3:
        if (!(lo[29] && !hi[29])) state_next = ST_FIN;
      ST_FIN: state_next = ST_OUT;
      ST_CONC:
        if (cnt != '0 && conc_done) state_next = ST_CEMIT;
        else if (cnt == '0 && range_low == '0 && range_high == '1) state_next = ST_CEMIT;
      ST_CEMIT: state_next = (lo + 32'd1 == hi) ? ST_FIN : ST_OUT;
      ST_OUT: if (out_ready) begin
        if (ret == ST_IDLE) state_next = ST_IDLE;
        else if (ret == ST_CEMIT) state_next = ST_CEMIT;
        else state_next = ST_EMIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ready)
    else $error("input accepted while busy");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last |=> state == ST_IDLE)
    else $error("last word did not end item");

endmodule
